[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Combinational property checked on every clock edge outside reset.
`define KL_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Property checked in the cycle after its trigger.
`define KL_ASSERT_NEXT(label, clk, rst, trig, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error("assertion failed");

`else

`define KL_ASSERT(label, clk, rst, expr)
`define KL_ASSERT_NEXT(label, clk, rst, trig, expr)

`endif

`endif

[hw/rtl/kwlex_pkg.sv]
// ----------------------------------------------------------------------------
// kwlex_pkg
// Token codes, keyword table, character constants and the result type of
// the keyword lexer.
// ----------------------------------------------------------------------------
package kwlex_pkg;

   localparam int MAX_TOKEN_LEN       = 128;
   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int LEN_BITS            = 8;
   localparam int START_BITS          = 16;
   localparam int KW_COUNT            = 7;
   localparam int KW_MAX_LEN          = 8;
   localparam int KW_IDX_BITS         = 3;
   localparam int FIFO_DEPTH          = 4;
   localparam int FIFO_PTR_BITS       = 2;
   localparam int FIFO_CNT_BITS       = 3;

   localparam int REQ_TDATA_BITS = 8;
   localparam int RSP_TDATA_BITS = 40;
   localparam int RSP_TUSER_BITS = 3;

   typedef enum logic [2:0] {
      CLS_IDENT   = 3'd0,
      CLS_NUMBER  = 3'd1,
      CLS_OPER    = 3'd2,
      CLS_KEYWORD = 3'd3,
      CLS_UNKNOWN = 3'd4
   } token_class_type;

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00},
      '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"p", "r", "o", "g", "r", "a", "m", "m"}
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd8
   };

   typedef struct packed {
      token_class_type         token_class;
      logic [KW_IDX_BITS-1:0]  keyword_index;
      logic [START_BITS-1:0]   token_start;
      logic [LEN_BITS-1:0]     token_length;
      logic [7:0]              lead_byte;
      logic                    has_equals;
      logic                    length_overflow;
      logic                    last_of_run;
   } rsp_item_type;

endpackage

[hw/rtl/keyword_lexer_top.sv]
// ----------------------------------------------------------------------------
// keyword_lexer_top
// Streaming tokenizer: one source byte per transaction in, token
// descriptors out (identifier, number, operator, keyword, unknown).
//
//   channel  dir  payload
//   req_*    in   tdata = in_byte, tlast = end_of_input
//   rsp_*    out  tdata = token fields, tuser = token_class,
//                 tlast = last_of_run
//
// One byte is accepted per cycle while req_tready is high; the scanner state
// updates in the same cycle and results enter a four-entry result queue.
// A byte that yields two tokens writes two entries to the result queue.
// req_tready is low while the queue holds three or more results.
// Synchronous active-high reset: scanner idle, offset zero, queue empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyword_lexer_top #(
   parameter int OFFSET_BITS = kwlex_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] in_byte
   input  logic [kwlex_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] keyword_index, [18:3] token_start, [26:19] token_length,
   // [34:27] lead_byte, [35] has_equals, [36] length_overflow, [39:37] zero
   output logic [kwlex_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   // [2:0] token_class
   output logic [kwlex_pkg::RSP_TUSER_BITS-1:0]  rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int LB = kwlex_pkg::LEN_BITS;
   localparam int PB = kwlex_pkg::FIFO_PTR_BITS;
   localparam int CB = kwlex_pkg::FIFO_CNT_BITS;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_OPER
   } mode_type;

   mode_type                           mode_ff, mode_in;
   logic [LB-1:0]                      len_ff, len_in;
   logic [kwlex_pkg::KW_COUNT-1:0]     kwm_ff, kwm_in;
   logic [7:0]                         lead_ff, lead_in;
   logic [OFFSET_BITS-1:0]             start_ff, start_in;
   logic [OFFSET_BITS-1:0]             pos_ff, pos_in;
   logic                               ovf_ff, ovf_in;

   kwlex_pkg::rsp_item_type            fifo_ff [kwlex_pkg::FIFO_DEPTH];
   logic [PB-1:0]                      wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0]                      count_ff;

   logic                               req_fire, rsp_fire;
   logic [7:0]                         in_byte;
   logic                               is_letter, is_digit, is_space, is_oper;
   logic                               used, extend_en;
   logic                               a_valid, b_valid, c_valid;
   kwlex_pkg::rsp_item_type            a_item, b_item, c_item;
   kwlex_pkg::rsp_item_type            first_item, second_item, head;
   logic [1:0]                         push_cnt;
   logic [31:0]                        pos_wide;

   function automatic kwlex_pkg::rsp_item_type flush_item(
      input mode_type                       m,
      input logic [LB-1:0]                  len,
      input logic [kwlex_pkg::KW_COUNT-1:0] kwm,
      input logic                           ovf,
      input logic [7:0]                     lead,
      input logic [OFFSET_BITS-1:0]         start
   );
      kwlex_pkg::rsp_item_type r;
      logic [31:0]             start_wide;
      logic                    found;
      int                      k;
      start_wide        = 32'(start);
      found             = 1'b0;
      r.token_class     = kwlex_pkg::CLS_IDENT;
      r.keyword_index   = '0;
      r.token_start     = start_wide[kwlex_pkg::START_BITS-1:0];
      r.token_length    = len;
      r.lead_byte       = lead;
      r.has_equals      = 1'b0;
      r.length_overflow = ovf;
      r.last_of_run     = 1'b0;
      unique case (m)
         MODE_IDENT: begin
            if (!ovf) begin
               for (k = 0; k < kwlex_pkg::KW_COUNT; k++) begin
                  if (!found && kwm[k] && len == LB'(kwlex_pkg::KW_LEN[k])) begin
                     found           = 1'b1;
                     r.token_class   = kwlex_pkg::CLS_KEYWORD;
                     r.keyword_index = kwlex_pkg::KW_IDX_BITS'(k);
                  end
               end
            end
         end
         MODE_NUMBER: begin
            r.token_class = kwlex_pkg::CLS_NUMBER;
         end
         MODE_OPER: begin
            r.token_class     = kwlex_pkg::CLS_OPER;
            r.token_length    = LB'(1);
            r.length_overflow = 1'b0;
         end
         MODE_IDLE: begin
         end
      endcase
      return r;
   endfunction

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= CB'(kwlex_pkg::FIFO_DEPTH - 2));
   assign in_byte    = req_tdata[7:0];

   always_comb begin : scan_blk
      int k;
      is_letter = (in_byte >= "A" && in_byte <= "Z") || (in_byte >= "a" && in_byte <= "z");
      is_digit  = (in_byte >= "0" && in_byte <= "9");
      is_space  = (in_byte >= kwlex_pkg::CH_TAB && in_byte <= kwlex_pkg::CH_CR) ||
                  (in_byte == kwlex_pkg::CH_SPACE);
      is_oper   = (in_byte == kwlex_pkg::CH_LT) || (in_byte == kwlex_pkg::CH_GT) ||
                  (in_byte == kwlex_pkg::CH_EQ) || (in_byte == kwlex_pkg::CH_BANG);

      used      = 1'b0;
      a_valid   = 1'b0;
      b_valid   = 1'b0;
      extend_en = 1'b0;
      a_item    = flush_item(mode_ff, len_ff, kwm_ff, ovf_ff, lead_ff, start_ff);

      mode_in  = mode_ff;
      len_in   = len_ff;
      kwm_in   = kwm_ff;
      lead_in  = lead_ff;
      start_in = start_ff;
      ovf_in   = ovf_ff;

      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_letter || is_digit) begin
               used      = 1'b1;
               extend_en = 1'b1;
            end else begin
               a_valid = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit || in_byte == kwlex_pkg::CH_DOT) begin
               used      = 1'b1;
               extend_en = 1'b1;
            end else begin
               a_valid = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_OPER: begin
            a_valid = 1'b1;
            mode_in = MODE_IDLE;
            if (in_byte == kwlex_pkg::CH_EQ) begin
               used                = 1'b1;
               a_item.token_length = LB'(2);
               a_item.has_equals   = 1'b1;
            end
         end
         MODE_IDLE: begin
         end
      endcase

      if (!used && !is_space) begin
         start_in = pos_ff;
         lead_in  = in_byte;
         len_in   = '0;
         ovf_in   = 1'b0;
         kwm_in   = '1;
         priority if (is_letter) begin
            mode_in   = MODE_IDENT;
            extend_en = 1'b1;
         end else if (is_digit) begin
            mode_in   = MODE_NUMBER;
            extend_en = 1'b1;
         end else if (is_oper) begin
            mode_in = MODE_OPER;
         end else begin
            b_valid = 1'b1;
         end
      end

      if (extend_en) begin
         if (len_in >= LB'(kwlex_pkg::MAX_TOKEN_LEN)) begin
            ovf_in = 1'b1;
            kwm_in = '0;
         end else begin
            for (k = 0; k < kwlex_pkg::KW_COUNT; k++) begin
               if (len_in >= LB'(kwlex_pkg::KW_LEN[k]) ||
                   kwlex_pkg::KW_TEXT[k][len_in[2:0]] != in_byte) begin
                  kwm_in[k] = 1'b0;
               end
            end
            len_in = len_in + LB'(1);
         end
      end

      pos_wide               = 32'(pos_ff);
      b_item.token_class     = kwlex_pkg::CLS_UNKNOWN;
      b_item.keyword_index   = '0;
      b_item.token_start     = pos_wide[kwlex_pkg::START_BITS-1:0];
      b_item.token_length    = LB'(1);
      b_item.lead_byte       = in_byte;
      b_item.has_equals      = 1'b0;
      b_item.length_overflow = 1'b0;
      b_item.last_of_run     = 1'b0;

      c_valid = req_tlast && (mode_in != MODE_IDLE);
      c_item  = flush_item(mode_in, len_in, kwm_in, ovf_in, lead_in, start_in);

      if (req_tlast) begin
         mode_in = MODE_IDLE;
         pos_in  = '0;
      end else begin
         pos_in = pos_ff + OFFSET_BITS'(1);
      end

      push_cnt    = 2'(a_valid) + 2'(b_valid) + 2'(c_valid);
      first_item  = a_valid ? a_item : (b_valid ? b_item : c_item);
      second_item = (a_valid && b_valid) ? b_item : c_item;
      if (push_cnt == 2'd1) begin
         first_item.last_of_run = 1'b1;
      end
      second_item.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         len_ff    <= '0;
         kwm_ff    <= '1;
         lead_ff   <= '0;
         start_ff  <= '0;
         pos_ff    <= '0;
         ovf_ff    <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_fire) begin
            mode_ff   <= mode_in;
            len_ff    <= len_in;
            kwm_ff    <= kwm_in;
            lead_ff   <= lead_in;
            start_ff  <= start_in;
            pos_ff    <= pos_in;
            ovf_ff    <= ovf_in;
            wr_ptr_ff <= wr_ptr_ff + PB'(push_cnt);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + PB'(1);
         end
         count_ff <= count_ff + (req_fire ? CB'(push_cnt) : CB'(0)) - CB'(rsp_fire);
      end
      if (req_fire && push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= first_item;
      end
      if (req_fire && push_cnt == 2'd2) begin
         fifo_ff[wr_ptr_ff + PB'(1)] <= second_item;
      end
   end

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {3'b000, head.length_overflow, head.has_equals, head.lead_byte,
                        head.token_length, head.token_start, head.keyword_index};
   assign rsp_tuser  = head.token_class;
   assign rsp_tlast  = head.last_of_run;

   `KL_ASSERT(a_queue_bound, clock, reset, count_ff <= CB'(kwlex_pkg::FIFO_DEPTH))
   `KL_ASSERT(a_len_bound, clock, reset, len_ff <= LB'(kwlex_pkg::MAX_TOKEN_LEN))
   `KL_ASSERT_NEXT(a_eoi_idle, clock, reset, req_fire && req_tlast, mode_ff == MODE_IDLE && pos_ff == '0)
   `KL_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_tvalid && !rsp_tready && !req_fire, $stable(count_ff) && $stable(rd_ptr_ff))

endmodule
